// ===== src/pcl_pkg.sv =====
// Shared types, codes and constants for the particle cell-list binning block.
`timescale 1ns / 1ps
`default_nettype none

package pcl_pkg;

    // Storage and field limits
    localparam int PCL_MAX_PARTICLES = 65536;
    localparam int PCL_MAX_CELLS     = 4096;
    localparam int PCL_ADDR_W        = 20;   // widest cell address the store may take
    localparam int PCL_CELL_W        = 12;
    localparam int PCL_HEAD_W        = 16;
    localparam int PCL_RAM_W         = PCL_HEAD_W + 1;   // occupied flag and head
    localparam int PCL_QUEUE_DEPTH   = 2;
    localparam int PCL_CFG_IDX_W     = 3;
    localparam int PCL_CFG_DATA_W    = 32;

    // Configuration register indexes
    localparam logic [PCL_CFG_IDX_W-1:0] REG_BOX_X_MAX     = 3'd0;
    localparam logic [PCL_CFG_IDX_W-1:0] REG_BOX_Y_MAX     = 3'd1;
    localparam logic [PCL_CFG_IDX_W-1:0] REG_BOX_Z_MAX     = 3'd2;
    localparam logic [PCL_CFG_IDX_W-1:0] REG_INV_CELL_SIZE = 3'd3;
    localparam logic [PCL_CFG_IDX_W-1:0] REG_CELLS_X       = 3'd4;
    localparam logic [PCL_CFG_IDX_W-1:0] REG_CELLS_Y       = 3'd5;
    localparam logic [PCL_CFG_IDX_W-1:0] REG_CELLS_Z       = 3'd6;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [30:0] box_x_max;
        logic [30:0] box_y_max;
        logic [30:0] box_z_max;
        logic [31:0] inv_cell_size;
        logic [12:0] cells_x;
        logic [12:0] cells_y;
        logic [12:0] cells_z;
    } t_cfg;

    // Command handed from the front end to the back end
    typedef struct packed {
        t_op                   op;
        logic [PCL_ADDR_W-1:0] addr;
        logic [PCL_CELL_W-1:0] out_cell;
        logic [PCL_HEAD_W-1:0] pidx;
        logic                  lookup_ok;
        logic                  write_ok;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/pcl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/pcl_front.sv =====
// Front end: accepts items, clamps and scales positions, forms the linear cell.
`timescale 1ns / 1ps
`default_nettype none

module pcl_front import pcl_pkg::*; #(
    parameter int MAX_CELLS = PCL_MAX_CELLS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_hold,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [15:0] i_particle_index,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    input  wire logic [11:0] i_query_cell,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LIN,
        S_SUM,
        S_PUSH
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [30:0] r_px, r_py, r_pz, n_px, n_py, n_pz;
    logic [11:0] r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;
    logic [24:0] r_cynx, n_cynx;
    logic [25:0] r_nxny, n_nxny;

    logic [12:0] nx, ny, nz;
    logic [62:0] prod_x, prod_y, prod_z;
    logic [37:0] prod_z_plane;
    logic [38:0] lin_sum;
    logic [38:0] lin_sat;
    logic        accept;
    t_op         in_op;

    // zero acts as one cell, anything above the grid limit saturates
    function automatic logic [12:0] grid_count(input logic [12:0] n);
        logic [12:0] c;
        if (n == 13'd0) begin
            c = 13'd1;
        end else if (n > 13'd4096) begin
            c = 13'd4096;
        end else begin
            c = n;
        end
        return c;
    endfunction

    function automatic logic [30:0] clamp_pos(input logic [31:0] p, input logic [30:0] bound);
        logic [30:0] c;
        if (p[31]) begin
            c = '0;
        end else if (p[30:0] > bound) begin
            c = bound;
        end else begin
            c = p[30:0];
        end
        return c;
    endfunction

    function automatic logic [11:0] clamp_cell(input logic [30:0] c, input logic [12:0] cnt);
        logic [12:0] top;
        logic [11:0] r;
        top = cnt - 13'd1;
        if (c > {18'd0, top}) begin
            r = top[11:0];
        end else begin
            r = c[11:0];
        end
        return r;
    endfunction

    assign nx = grid_count(i_cfg.cells_x);
    assign ny = grid_count(i_cfg.cells_y);
    assign nz = grid_count(i_cfg.cells_z);

    assign prod_x = r_px * i_cfg.inv_cell_size;
    assign prod_y = r_py * i_cfg.inv_cell_size;
    assign prod_z = r_pz * i_cfg.inv_cell_size;

    assign prod_z_plane = r_cz * r_nxny;
    assign lin_sum      = 39'(r_cx) + 39'(r_cynx) + 39'(prod_z_plane);
    assign lin_sat      = (lin_sum > 39'(MAX_CELLS - 1)) ? 39'(MAX_CELLS - 1) : lin_sum;

    assign o_stall = (r_state != S_IDLE) || i_hold;
    assign accept  = i_valid && !o_stall;
    assign in_op   = t_op'(i_operation);
    assign o_push  = (r_state == S_PUSH) && !i_q_full;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_px    = r_px;
        n_py    = r_py;
        n_pz    = r_pz;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cz    = r_cz;
        n_cynx  = r_cynx;
        n_nxny  = r_nxny;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd.op        = in_op;
                    n_cmd.pidx      = i_particle_index;
                    n_cmd.write_ok  = (in_op == OP_INSERT) &&
                                      (32'(i_particle_index) < 32'(PCL_MAX_PARTICLES));
                    n_cmd.lookup_ok = (in_op == OP_INSERT) ||
                                      ((in_op == OP_READ) &&
                                       (32'(i_query_cell) < 32'(MAX_CELLS)));
                    n_cmd.out_cell  = (in_op == OP_READ) ? i_query_cell : '0;
                    n_cmd.addr      = (in_op == OP_READ) ? PCL_ADDR_W'(i_query_cell) : '0;
                    n_px            = clamp_pos(i_pos_x, i_cfg.box_x_max);
                    n_py            = clamp_pos(i_pos_y, i_cfg.box_y_max);
                    n_pz            = clamp_pos(i_pos_z, i_cfg.box_z_max);
                    n_state         = (in_op == OP_INSERT) ? S_MUL : S_PUSH;
                end
            end
            S_MUL: begin
                // floor of position times inverse cell size, clamped to the grid
                n_cx    = clamp_cell(prod_x[62:32], nx);
                n_cy    = clamp_cell(prod_y[62:32], ny);
                n_cz    = clamp_cell(prod_z[62:32], nz);
                n_state = S_LIN;
            end
            S_LIN: begin
                n_cynx  = r_cy * nx;
                n_nxny  = nx * ny;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_cmd.addr     = PCL_ADDR_W'(lin_sat);
                n_cmd.out_cell = lin_sat[PCL_CELL_W-1:0];
                n_state        = S_PUSH;
            end
            S_PUSH: begin
                if (!i_q_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd  <= n_cmd;
        r_px   <= n_px;
        r_py   <= n_py;
        r_pz   <= n_pz;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_cynx <= n_cynx;
        r_nxny <= n_nxny;
    end

endmodule

`default_nettype wire

// ===== src/pcl_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module pcl_queue import pcl_pkg::*; #(
    parameter int DEPTH = PCL_QUEUE_DEPTH,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        if (p == PW'(DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PW'(1);
        end
        return n;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= next_ptr(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= next_ptr(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== src/pcl_back.sv =====
// Back end: cell store updates, clear sweeps and the result register.
`timescale 1ns / 1ps
`default_nettype none

module pcl_back import pcl_pkg::*; #(
    parameter int MAX_CELLS = PCL_MAX_CELLS,
    localparam int CW       = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    output logic             o_init_busy,
    input  wire logic        i_q_empty,
    input  wire t_cmd        i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [11:0]      o_cell_index,
    output logic             o_has_link,
    output logic [15:0]      o_link_particle
);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CLR
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cur, n_cur;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [PCL_CELL_W-1:0] r_out_cell, n_out_cell;
    logic                  r_out_has, n_out_has;
    logic [PCL_HEAD_W-1:0] r_out_link, n_out_link;
    logic                  n_out_load;
    logic                  out_free;

    logic                  ram_we;
    logic [CW-1:0]         ram_waddr, ram_raddr;
    logic [PCL_RAM_W-1:0]  ram_wdata, ram_rdata;
    logic                  hit;

    pcl_ram #(
        .WIDTH (PCL_RAM_W),
        .DEPTH (MAX_CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign hit         = r_cur.lookup_ok && ram_rdata[PCL_HEAD_W];
    assign o_init_busy = (r_state == S_INIT);

    assign o_out_valid     = r_out_valid;
    assign o_cell_index    = r_out_cell;
    assign o_has_link      = r_out_has;
    assign o_link_particle = r_out_link;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_out_load  = 1'b0;
        n_out_cell  = r_out_cell;
        n_out_has   = r_out_has;
        n_out_link  = r_out_link;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt;
        ram_wdata   = '0;
        ram_raddr   = CW'(i_cmd.addr);
        case (r_state)
            S_INIT: begin
                // empty every cell after reset, no result
                ram_we = 1'b1;
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CW'(MAX_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    n_cur = i_cmd;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLR;
                        end
                        OP_INSERT, OP_READ: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_out_load = 1'b1;
                            n_out_cell = '0;
                            n_out_has  = 1'b0;
                            n_out_link = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                // read data is back: report, and for a valid insert make the particle the new head
                n_out_load = 1'b1;
                n_out_cell = r_cur.out_cell;
                n_out_has  = hit;
                n_out_link = hit ? ram_rdata[PCL_HEAD_W-1:0] : '0;
                ram_we     = r_cur.write_ok;
                ram_waddr  = CW'(r_cur.addr);
                ram_wdata  = {1'b1, r_cur.pidx};
                n_state    = S_IDLE;
            end
            S_CLR: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CW'(MAX_CELLS - 1)) begin
                    n_out_load = 1'b1;
                    n_out_cell = '0;
                    n_out_has  = 1'b0;
                    n_out_link = '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cur      <= n_cur;
        r_out_cell <= n_out_cell;
        r_out_has  <= n_out_has;
        r_out_link <= n_out_link;
    end

    a_rd_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ($past(r_state) == S_IDLE))
        else $error("lookup finished without a read issued");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !n_out_load)
        else $error("result register overwritten while held");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("cell store written while idle");

endmodule

`default_nettype wire

// ===== src/particle_cell_list_binning_core.sv =====
// Top level of the particle cell-list binning block: configuration and wiring.
`timescale 1ns / 1ps
`default_nettype none

// Bins particles into a uniform grid and keeps one linked list per cell. Operation 1
// inserts a particle and returns its cell, the cell's previous head as its next link,
// and makes it the new head; operation 2 reads a cell's head; operation 0 empties all
// cells. The front end takes an item, then needs three arithmetic steps (axis multiply,
// plane products, linear sum) and a queue push before it takes the next item; reads
// and clears go straight to the queue push. The back end handles an insert or read as
// a cell store read, then a write-back, and a clear as a sweep of the store one cell a
// cycle; a two-entry queue lets the front keep working during a sweep. After reset the
// block clears the store and holds o_in_stall high meanwhile; configuration writes are
// taken at any time but must only change while idle.
module particle_cell_list_binning_core import pcl_pkg::*; #(
    parameter int MAX_CELLS   = PCL_MAX_CELLS,
    parameter int QUEUE_DEPTH = PCL_QUEUE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [PCL_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [PCL_CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_operation,
    input  wire logic [15:0]               i_particle_index,
    input  wire logic [31:0]               i_pos_x,
    input  wire logic [31:0]               i_pos_y,
    input  wire logic [31:0]               i_pos_z,
    input  wire logic [11:0]               i_query_cell,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [11:0]                    o_cell_index,
    output logic                           o_has_link,
    output logic [15:0]                    o_link_particle
);

    t_cfg r_cfg;
    logic init_busy;
    logic q_push, q_pop, q_full, q_empty;
    t_cmd front_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_x_max     <= '0;
            r_cfg.box_y_max     <= '0;
            r_cfg.box_z_max     <= '0;
            r_cfg.inv_cell_size <= 32'd65536;
            r_cfg.cells_x       <= 13'd1;
            r_cfg.cells_y       <= 13'd1;
            r_cfg.cells_z       <= 13'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BOX_X_MAX:     r_cfg.box_x_max     <= i_cfg_data[30:0];
                REG_BOX_Y_MAX:     r_cfg.box_y_max     <= i_cfg_data[30:0];
                REG_BOX_Z_MAX:     r_cfg.box_z_max     <= i_cfg_data[30:0];
                REG_INV_CELL_SIZE: r_cfg.inv_cell_size <= i_cfg_data;
                REG_CELLS_X:       r_cfg.cells_x       <= i_cfg_data[12:0];
                REG_CELLS_Y:       r_cfg.cells_y       <= i_cfg_data[12:0];
                REG_CELLS_Z:       r_cfg.cells_z       <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    pcl_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_hold           (init_busy),
        .i_cfg            (r_cfg),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_operation      (i_operation),
        .i_particle_index (i_particle_index),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_query_cell     (i_query_cell),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_cmd            (front_cmd)
    );

    pcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    pcl_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .o_init_busy     (init_busy),
        .i_q_empty       (q_empty),
        .i_cmd           (q_cmd),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cell_index    (o_cell_index),
        .o_has_link      (o_has_link),
        .o_link_particle (o_link_particle)
    );

endmodule

`default_nettype wire
